// ===== rtl/dmp_pkg.sv =====
// Shared types, constants and field helpers for the dilated 3-D max pooling block.
// Used by every module under rtl/; depends on nothing.
`timescale 1ns / 1ps

package dmp_pkg;

   localparam int DIM_MAX_DEF      = 16;
   localparam int KERNEL_MAX_DEF   = 8;
   localparam int SAMPLE_WIDTH_DEF = 16;

   localparam int POS_WIDTH      = 4;
   localparam int CNT_WIDTH      = 4;
   localparam int TAP_WIDTH      = 3;
   localparam int COORD_WIDTH    = 10;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 15;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_KERNEL   = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_STRIDE   = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PAD      = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DILATION = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_VOLUME   = 3'd4;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic [11:0] kernel_sizes;
      logic [11:0] strides;
      logic [11:0] pads;
      logic [11:0] dilations;
      logic [14:0] volume_sizes;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      kernel_sizes: 12'd546,
      strides:      12'd546,
      pads:         12'd0,
      dilations:    12'd273,
      volume_sizes: 15'd16912
   };

   typedef struct packed {
      logic                 hit;
      logic                 last;
      logic [TAP_WIDTH-1:0] tz;
      logic [TAP_WIDTH-1:0] ty;
      logic [TAP_WIDTH-1:0] tx;
   } tap_type;

   // axis 0 = t (high bits), 2 = w (low bits)
   function automatic logic [3:0] field4(input logic [11:0] r, input int axis);
      return r[4*(2-axis) +: 4];
   endfunction

   function automatic logic [4:0] field5(input logic [14:0] r, input int axis);
      return r[5*(2-axis) +: 5];
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] start_coord(
      input logic [POS_WIDTH-1:0] pos,
      input logic [3:0]           stride,
      input logic [3:0]           pad
   );
      logic [7:0] prod;
      prod = 8'(pos) * 8'(stride);
      return $signed({2'b00, prod}) - $signed({6'b000000, pad});
   endfunction

endpackage

// ===== rtl/dmp_store.sv =====
// Sample store: one write port, one read port with registered read data.
// Depends on dmp_pkg for defaults.
`timescale 1ns / 1ps

module dmp_store #(
   parameter int DIM_MAX      = dmp_pkg::DIM_MAX_DEF,
   parameter int SAMPLE_WIDTH = dmp_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [$clog2(DIM_MAX**3)-1:0]        wr_addr,
   input  logic [SAMPLE_WIDTH-1:0]              wr_data,
   input  logic                                 rd_en,
   input  logic [$clog2(DIM_MAX**3)-1:0]        rd_addr,
   output logic [SAMPLE_WIDTH-1:0]              rd_data
);

   localparam int DEPTH = DIM_MAX**3;

   logic [SAMPLE_WIDTH-1:0] store_ff [DEPTH];
   logic [SAMPLE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/dmp_scan.sv =====
// Tap sequencer: walks the kernel window one tap per cycle in t, h, w order
// and issues store reads for taps inside the volume. Depends on dmp_pkg.
`timescale 1ns / 1ps

module dmp_scan #(
   parameter int DIM_MAX    = dmp_pkg::DIM_MAX_DEF,
   parameter int KERNEL_MAX = dmp_pkg::KERNEL_MAX_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [dmp_pkg::POS_WIDTH-1:0]        pos_t,
   input  logic [dmp_pkg::POS_WIDTH-1:0]        pos_h,
   input  logic [dmp_pkg::POS_WIDTH-1:0]        pos_w,
   input  dmp_pkg::cfg_type                     cfg,
   output dmp_pkg::tap_type                     tap,
   output logic [$clog2(DIM_MAX**3)-1:0]        rd_addr
);

   localparam int AW = $clog2(DIM_MAX**3);
   localparam int CW = $clog2(DIM_MAX);
   localparam int VW = $clog2(DIM_MAX+1);
   localparam int KW = dmp_pkg::CNT_WIDTH;
   localparam int PW = dmp_pkg::COORD_WIDTH;

   logic                 active_ff, active_in;
   logic                 empty_ff, empty_in;
   logic [KW-1:0]        k_ff [3];
   logic [KW-1:0]        k_in [3];
   logic [3:0]           d_ff [3];
   logic [3:0]           d_in [3];
   logic [VW-1:0]        v_ff [3];
   logic [VW-1:0]        v_in [3];
   logic [KW-1:0]        n_ff [3];
   logic [KW-1:0]        n_in [3];
   logic signed [PW-1:0] c_ff [3];
   logic signed [PW-1:0] c_in [3];
   logic signed [PW-1:0] b_ff [1:2];
   logic signed [PW-1:0] b_in [1:2];

   logic [dmp_pkg::POS_WIDTH-1:0] pos [3];
   logic [3:0]                    kf;
   logic [4:0]                    vf;
   logic [2:0]                    wrap;
   logic [2:0]                    in_vol;
   logic                          last;

   assign pos[0] = pos_t;
   assign pos[1] = pos_h;
   assign pos[2] = pos_w;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         wrap[a]   = (n_ff[a] == k_ff[a] - KW'(1));
         in_vol[a] = (c_ff[a] >= 0) && (c_ff[a] < $signed(PW'(v_ff[a])));
      end
   end

   assign last = active_ff & (empty_ff | (&wrap));

   always_comb begin
      active_in = active_ff;
      empty_in  = empty_ff;
      kf        = '0;
      vf        = '0;
      for (int a = 0; a < 3; a++) begin
         k_in[a] = k_ff[a];
         d_in[a] = d_ff[a];
         v_in[a] = v_ff[a];
         n_in[a] = n_ff[a];
         c_in[a] = c_ff[a];
      end
      b_in[1] = b_ff[1];
      b_in[2] = b_ff[2];
      if (start) begin
         active_in = 1'b1;
         empty_in  = 1'b0;
         for (int a = 0; a < 3; a++) begin
            kf      = dmp_pkg::field4(cfg.kernel_sizes, a);
            vf      = dmp_pkg::field5(cfg.volume_sizes, a);
            k_in[a] = (kf > KERNEL_MAX) ? KW'(KERNEL_MAX) : kf;
            v_in[a] = (vf > DIM_MAX) ? VW'(DIM_MAX) : VW'(vf);
            d_in[a] = dmp_pkg::field4(cfg.dilations, a);
            n_in[a] = '0;
            c_in[a] = dmp_pkg::start_coord(pos[a], dmp_pkg::field4(cfg.strides, a),
                                           dmp_pkg::field4(cfg.pads, a));
            if (kf == 4'd0) begin
               empty_in = 1'b1;
            end
         end
         b_in[1] = c_in[1];
         b_in[2] = c_in[2];
      end else if (active_ff) begin
         if (last) begin
            active_in = 1'b0;
         end else if (!wrap[2]) begin
            n_in[2] = n_ff[2] + KW'(1);
            c_in[2] = c_ff[2] + PW'(d_ff[2]);
         end else begin
            n_in[2] = '0;
            c_in[2] = b_ff[2];
            if (!wrap[1]) begin
               n_in[1] = n_ff[1] + KW'(1);
               c_in[1] = c_ff[1] + PW'(d_ff[1]);
            end else begin
               n_in[1] = '0;
               c_in[1] = b_ff[1];
               n_in[0] = n_ff[0] + KW'(1);
               c_in[0] = c_ff[0] + PW'(d_ff[0]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      empty_ff <= empty_in;
      for (int a = 0; a < 3; a++) begin
         k_ff[a] <= k_in[a];
         d_ff[a] <= d_in[a];
         v_ff[a] <= v_in[a];
         n_ff[a] <= n_in[a];
         c_ff[a] <= c_in[a];
      end
      b_ff[1] <= b_in[1];
      b_ff[2] <= b_in[2];
   end

   assign tap.hit  = active_ff & ~empty_ff & (&in_vol);
   assign tap.last = last;
   assign tap.tz   = n_ff[0][dmp_pkg::TAP_WIDTH-1:0];
   assign tap.ty   = n_ff[1][dmp_pkg::TAP_WIDTH-1:0];
   assign tap.tx   = n_ff[2][dmp_pkg::TAP_WIDTH-1:0];

   assign rd_addr = AW'(c_ff[0][CW-1:0]) * AW'(DIM_MAX*DIM_MAX)
                  + AW'(c_ff[1][CW-1:0]) * AW'(DIM_MAX)
                  + AW'(c_ff[2][CW-1:0]);

endmodule

// ===== rtl/dmp_max.sv =====
// Running maximum: compares each returned sample with the best so far and
// keeps the first strict maximum with its tap offsets. Depends on dmp_pkg.
`timescale 1ns / 1ps

module dmp_max #(
   parameter int SAMPLE_WIDTH = dmp_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              clear,
   input  dmp_pkg::tap_type                  tap,
   input  logic [SAMPLE_WIDTH-1:0]           rd_data,
   output logic [SAMPLE_WIDTH-1:0]           max_value,
   output logic [dmp_pkg::TAP_WIDTH-1:0]     max_t,
   output logic [dmp_pkg::TAP_WIDTH-1:0]     max_h,
   output logic [dmp_pkg::TAP_WIDTH-1:0]     max_w,
   output logic                              found
);

   localparam int TW = dmp_pkg::TAP_WIDTH;

   logic                    hit_ff, hit_in;
   logic [TW-1:0]           tz_ff, ty_ff, tx_ff;
   logic                    found_ff, found_in;
   logic [SAMPLE_WIDTH-1:0] best_ff, best_in;
   logic [TW-1:0]           bt_ff, bt_in, bh_ff, bh_in, bw_ff, bw_in;
   logic                    take;

   assign hit_in = tap.hit;
   assign take   = hit_ff & (~found_ff | ($signed(rd_data) > $signed(best_ff)));

   always_comb begin
      found_in = found_ff;
      best_in  = best_ff;
      bt_in    = bt_ff;
      bh_in    = bh_ff;
      bw_in    = bw_ff;
      if (clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
         best_in  = rd_data;
         bt_in    = tz_ff;
         bh_in    = ty_ff;
         bw_in    = tx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff   <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         hit_ff   <= hit_in;
         found_ff <= found_in;
      end
      tz_ff   <= tap.tz;
      ty_ff   <= tap.ty;
      tx_ff   <= tap.tx;
      best_ff <= best_in;
      bt_ff   <= bt_in;
      bh_ff   <= bh_in;
      bw_ff   <= bw_in;
   end

   assign max_value = found_ff ? best_ff : {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   assign max_t     = found_ff ? bt_ff : '0;
   assign max_h     = found_ff ? bh_ff : '0;
   assign max_w     = found_ff ? bw_ff : '0;
   assign found     = found_ff;

endmodule

// ===== rtl/dilated_max_pool_3d.sv =====
// Dilated 3-D max pooling with argmax over one stored volume slice.
// A query with N = kt*kh*kw taps (N = 1 when an extent is zero) scans them,
// then drains and loads its result into the output register; the next beat is
// taken after that load, later while the previous result waits on rsp_tready.
// Reset idles the control and reloads the default configuration; the sample
// store is not cleared. The scan issues one read per cycle while on in-volume taps.
`timescale 1ns / 1ps

module dilated_max_pool_3d #(
   parameter int DIM_MAX      = dmp_pkg::DIM_MAX_DEF,
   parameter int KERNEL_MAX   = dmp_pkg::KERNEL_MAX_DEF,
   parameter int SAMPLE_WIDTH = dmp_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // pos_t, pos_h, pos_w, sample, zero fill
   input  logic [((12+SAMPLE_WIDTH+7)/8)*8-1:0]     req_tdata,
   // req_type
   input  logic                                     req_tuser,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // max_value, max_t, max_h, max_w, zero fill
   output logic [((SAMPLE_WIDTH+9+7)/8)*8-1:0]      rsp_tdata,
   // found
   output logic                                     rsp_tuser,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [dmp_pkg::CSR_IDX_WIDTH-1:0]        csr_index,
   input  logic [dmp_pkg::CSR_DATA_WIDTH-1:0]       csr_data
);

   localparam int RSP_W = ((SAMPLE_WIDTH+9+7)/8)*8;
   localparam int AW    = $clog2(DIM_MAX**3);
   localparam int TW    = dmp_pkg::TAP_WIDTH;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]             state_ff, state_in;
   dmp_pkg::cfg_type       cfg_ff, cfg_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                   rsp_found_ff, rsp_found_in;

   logic [3:0]              pos_t, pos_h, pos_w;
   logic [SAMPLE_WIDTH-1:0] sample;
   logic                    req_beat;
   logic                    start;
   logic                    wr_ok;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [AW-1:0]           rd_addr;
   logic [SAMPLE_WIDTH-1:0] rd_data;
   dmp_pkg::tap_type        tap;
   logic [SAMPLE_WIDTH-1:0] max_value;
   logic [TW-1:0]           max_t, max_h, max_w;
   logic                    found;
   logic                    load;

   assign pos_t  = req_tdata[3:0];
   assign pos_h  = req_tdata[7:4];
   assign pos_w  = req_tdata[11:8];
   assign sample = req_tdata[12 +: SAMPLE_WIDTH];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid & req_tready;
   assign start      = req_beat & (req_tuser == dmp_pkg::REQ_QUERY);

   // drop writes that fall outside the store
   assign wr_ok   = (pos_t < DIM_MAX) && (pos_h < DIM_MAX) && (pos_w < DIM_MAX);
   assign wr_en   = req_beat & (req_tuser == dmp_pkg::REQ_WRITE) & wr_ok;
   assign wr_addr = AW'(pos_t) * AW'(DIM_MAX*DIM_MAX) + AW'(pos_h) * AW'(DIM_MAX)
                  + AW'(pos_w);

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid & csr_ready) begin
         case (csr_index)
            dmp_pkg::CSR_KERNEL:   cfg_in.kernel_sizes = csr_data[11:0];
            dmp_pkg::CSR_STRIDE:   cfg_in.strides      = csr_data[11:0];
            dmp_pkg::CSR_PAD:      cfg_in.pads         = csr_data[11:0];
            dmp_pkg::CSR_DILATION: cfg_in.dilations    = csr_data[11:0];
            dmp_pkg::CSR_VOLUME:   cfg_in.volume_sizes = csr_data[14:0];
            default: begin
            end
         endcase
      end
   end

   dmp_store #(
      .DIM_MAX      (DIM_MAX),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (sample),
      .rd_en   (tap.hit),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dmp_scan #(
      .DIM_MAX    (DIM_MAX),
      .KERNEL_MAX (KERNEL_MAX)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .pos_t   (pos_t),
      .pos_h   (pos_h),
      .pos_w   (pos_w),
      .cfg     (cfg_ff),
      .tap     (tap),
      .rd_addr (rd_addr)
   );

   dmp_max #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_max (
      .clock     (clock),
      .reset     (reset),
      .clear     (start),
      .tap       (tap),
      .rd_data   (rd_data),
      .max_value (max_value),
      .max_t     (max_t),
      .max_h     (max_h),
      .max_w     (max_w),
      .found     (found)
   );

   // hold the finished result until the output register is free
   assign load = (state_ff == ST_DONE) & (~rsp_valid_ff | rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tap.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_found_in = rsp_found_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({max_w, max_h, max_t, max_value});
         rsp_found_in = found;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ff       <= dmp_pkg::CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_found_ff;

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      tap.hit |-> state_ff == ST_SCAN)
      else $error("store read issued outside a scan");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == ST_IDLE && !tap.hit)
      else $error("store write overlaps a scan");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && tap.last |=> state_ff == ST_DRAIN && !tap.hit)
      else $error("scan did not stop after its last tap");

   a_empty_taps: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[SAMPLE_WIDTH +: 9] == '0)
      else $error("tap offsets set on an empty window");

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for dilated_max_pool_3d: sample writes, pooling queries and
// register settings, with results predicted here and compared beat by beat.
// Depends on rtl/dmp_pkg.sv and rtl/dilated_max_pool_3d.sv.
`timescale 1ns / 1ps

module tb_top;
   import dmp_pkg::*;

   localparam int DIM           = DIM_MAX_DEF;
   localparam int KMAX          = KERNEL_MAX_DEF;
   localparam int RANDOM_ITEMS  = 1150;
   localparam int SETTLE_CYCLES = 8;
   localparam int END_CYCLES    = 600;
   localparam int CYCLE_LIMIT   = 6000000;

   typedef struct packed {
      logic               found;
      logic [2:0]         tx;
      logic [2:0]         ty;
      logic [2:0]         tz;
      logic signed [15:0] value;
   } pooled_max_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = REQ_WRITE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_WIDTH-1:0]  csr_index = CSR_KERNEL;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   cfg_type            pool_cfg = CFG_RESET;
   logic signed [15:0] store_model [DIM*DIM*DIM];
   bit                 cell_written [DIM*DIM*DIM];
   int                 unfilled_cells [$];
   pooled_max_type     pending_maxima [$];
   pooled_max_type     want;
   int                 mismatches = 0;
   int                 items_accepted = 0;
   int                 cycle_count = 0;
   int                 stall_left = 0;
   int                 stall_roll;
   bit                 sender_idling = 1'b1;
   bit                 receiver_idling = 1'b1;

   dilated_max_pool_3d DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // worst case is about 1400 beats of 512 taps each with long gaps and stalls
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("dilated_max_pool_3d verification failed");
         $finish;
      end
   end

   function automatic pooled_max_type predict_pool(input logic [3:0] ot, oh, ow);
      pooled_max_type     r;
      int                 pos [3];
      int                 ext [3];
      int                 dil [3];
      int                 vol [3];
      int                 org [3];
      int                 a, z, y, x, ct, ch, cw, addr;
      logic signed [15:0] v;
      pos[0] = int'(ot);
      pos[1] = int'(oh);
      pos[2] = int'(ow);
      r = '0;
      r.value = 16'sh8000;
      unfilled_cells.delete();
      for (a = 0; a < 3; a++) begin
         ext[a] = int'(pool_cfg.kernel_sizes[4*(2-a) +: 4]);
         if (ext[a] > KMAX) ext[a] = KMAX;
         dil[a] = int'(pool_cfg.dilations[4*(2-a) +: 4]);
         vol[a] = int'(pool_cfg.volume_sizes[5*(2-a) +: 5]);
         if (vol[a] > DIM) vol[a] = DIM;
         org[a] = pos[a] * int'(pool_cfg.strides[4*(2-a) +: 4])
                  - int'(pool_cfg.pads[4*(2-a) +: 4]);
      end
      for (z = 0; z < ext[0]; z++) begin
         ct = org[0] + z * dil[0];
         if (ct < 0 || ct >= vol[0]) continue;
         for (y = 0; y < ext[1]; y++) begin
            ch = org[1] + y * dil[1];
            if (ch < 0 || ch >= vol[1]) continue;
            for (x = 0; x < ext[2]; x++) begin
               cw = org[2] + x * dil[2];
               if (cw < 0 || cw >= vol[2]) continue;
               addr = (ct * DIM + ch) * DIM + cw;
               if (!cell_written[addr]) unfilled_cells.push_back(addr);
               v = store_model[addr];
               if (!r.found || v > $signed(r.value)) begin
                  r.found = 1'b1;
                  r.value = v;
                  r.tz = z[2:0];
                  r.ty = y[2:0];
                  r.tx = x[2:0];
               end
            end
         end
      end
      return r;
   endfunction

   function automatic int sender_gap();
      int r;
      if (!sender_idling) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (!receiver_idling) begin
         rsp_tready <= 1'b1;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 70) begin
            rsp_tready <= 1'b1;
         end else if (stall_roll < 96) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(10, 60);
         end
      end
   end

   task automatic check_field(input string name, input logic signed [31:0] exp_v,
                              input logic signed [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_maxima.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual max_value %0d found %0b",
                     $time, $signed(rsp_tdata[15:0]), rsp_tuser);
            mismatches++;
         end else begin
            want = pending_maxima.pop_front();
            check_field("max_value", 32'($signed(want.value)), 32'($signed(rsp_tdata[15:0])));
            check_field("max_t", 32'(want.tz), 32'(rsp_tdata[18:16]));
            check_field("max_h", 32'(want.ty), 32'(rsp_tdata[21:19]));
            check_field("max_w", 32'(want.tx), 32'(rsp_tdata[24:22]));
            check_field("found", 32'(want.found), 32'(rsp_tuser));
         end
      end
   end

   // called at a falling edge; leaves req_tvalid high for a back-to-back beat
   task automatic send_beat(input logic kind, input logic [3:0] t, h, w,
                            input logic [15:0] s);
      int n;
      n = sender_gap();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_tuser  <= kind;
      req_tdata  <= {4'h0, s, w, h, t};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_accepted++;
      if (kind == REQ_WRITE) begin
         store_model[{t, h, w}] = s;
         cell_written[{t, h, w}] = 1'b1;
      end else begin
         pending_maxima.push_back(predict_pool(t, h, w));
      end
      @(negedge clock);
   endtask

   // fill every tap cell the window touches before asking for it
   task automatic run_query(input logic [3:0] t, h, w);
      int fill [$];
      void'(predict_pool(t, h, w));
      fill = unfilled_cells;
      foreach (fill[i]) begin
         if (!cell_written[fill[i]])
            send_beat(REQ_WRITE, fill[i][11:8], fill[i][7:4], fill[i][3:0], 16'($urandom));
      end
      send_beat(REQ_QUERY, t, h, w, 16'($urandom));
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_maxima.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic cfg_write(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_KERNEL:   pool_cfg.kernel_sizes = value[11:0];
         CSR_STRIDE:   pool_cfg.strides      = value[11:0];
         CSR_PAD:      pool_cfg.pads         = value[11:0];
         CSR_DILATION: pool_cfg.dilations    = value[11:0];
         CSR_VOLUME:   pool_cfg.volume_sizes = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [11:0] pack3(input int t, h, w);
      return {t[3:0], h[3:0], w[3:0]};
   endfunction

   function automatic logic [14:0] pack5(input int t, h, w);
      return {t[4:0], h[4:0], w[4:0]};
   endfunction

   // unused upper data bits of the 12-bit registers carry random junk
   task automatic cfg_all(input logic [11:0] k, s, p, d, input logic [14:0] v);
      drain_results();
      cfg_write(CSR_KERNEL,   {3'($urandom_range(0, 7)), k});
      cfg_write(CSR_STRIDE,   {3'($urandom_range(0, 7)), s});
      cfg_write(CSR_PAD,      {3'($urandom_range(0, 7)), p});
      cfg_write(CSR_DILATION, {3'($urandom_range(0, 7)), d});
      cfg_write(CSR_VOLUME,   v);
   endtask

   function automatic int pick_kernel();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) return $urandom_range(0, 15);
      if (r < 16) return $urandom_range(4, 8);
      return $urandom_range(1, 3);
   endfunction

   function automatic int pick_step();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return $urandom_range(0, 15);
      return $urandom_range(1, 3);
   endfunction

   function automatic int pick_pad();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return 1;
      return $urandom_range(0, 15);
   endfunction

   function automatic int pick_volume();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return $urandom_range(0, 31);
      if (r < 25) return 16;
      return $urandom_range(2, 8);
   endfunction

   function automatic int pick_out();
      if ($urandom_range(0, 99) < 75) return $urandom_range(0, 3);
      return $urandom_range(0, 15);
   endfunction

   task automatic test_default_window();
      logic signed [15:0] vals [8];
      vals = '{16'sh8000, 16'sd100, 16'sd32767, -16'sd1, 16'sd32767, 16'sd0, -16'sd2, 16'sd5};
      for (int i = 0; i < 8; i++)
         send_beat(REQ_WRITE, 4'(i / 4), 4'((i / 2) % 2), 4'(i % 2), vals[i]);
      send_beat(REQ_WRITE, 15, 15, 15, 16'sh8000);
      run_query(0, 0, 0);
      run_query(15, 15, 15);
      run_query(1, 0, 1);
   endtask

   task automatic test_edge_settings();
      cfg_all(pack3(0, 2, 2), pack3(2, 2, 2), pack3(0, 0, 0), pack3(1, 1, 1),
              pack5(16, 16, 16));
      run_query(0, 0, 0);
      cfg_all(pack3(15, 1, 1), pack3(1, 1, 1), pack3(0, 0, 0), pack3(1, 1, 1),
              pack5(16, 16, 16));
      send_beat(REQ_WRITE, 7, 5, 5, 16'sd32767);
      run_query(0, 5, 5);
      cfg_all(pack3(2, 2, 2), pack3(2, 2, 2), pack3(0, 0, 0), pack3(1, 1, 1),
              pack5(0, 16, 16));
      run_query(0, 0, 0);
      cfg_all(pack3(2, 2, 2), pack3(15, 15, 15), pack3(0, 0, 0), pack3(1, 1, 1),
              pack5(31, 31, 31));
      run_query(1, 1, 1);
      cfg_all(pack3(3, 3, 3), pack3(0, 0, 0), pack3(0, 0, 0), pack3(0, 0, 0),
              pack5(16, 16, 16));
      run_query(9, 4, 15);
      cfg_all(pack3(2, 2, 2), pack3(15, 15, 15), pack3(15, 15, 15), pack3(15, 15, 15),
              pack5(16, 16, 16));
      run_query(0, 0, 0);
      run_query(1, 1, 1);
   endtask

   task automatic test_random_traffic();
      int base, phase_len, r;
      base = items_accepted;
      while (items_accepted - base < RANDOM_ITEMS) begin
         cfg_all(pack3(pick_kernel(), pick_kernel(), pick_kernel()),
                 pack3(pick_step(), pick_step(), pick_step()),
                 pack3(pick_pad(), pick_pad(), pick_pad()),
                 pack3(pick_step(), pick_step(), pick_step()),
                 pack5(pick_volume(), pick_volume(), pick_volume()));
         sender_idling   = ($urandom_range(0, 3) != 0);
         receiver_idling = ($urandom_range(0, 3) != 0);
         phase_len = $urandom_range(30, 110);
         for (int i = 0; i < phase_len && items_accepted - base < RANDOM_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 2)
               drain_results();
            else if (r < 37)
               send_beat(REQ_WRITE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                         4'($urandom_range(0, 15)), 16'($urandom));
            else
               run_query(4'(pick_out()), 4'(pick_out()), 4'(pick_out()));
         end
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_default_window();
      test_edge_settings();
      test_random_traffic();
      drain_results();
      repeat (END_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("dilated_max_pool_3d verification clean");
      else
         $display("dilated_max_pool_3d verification failed");
      $finish;
   end

endmodule
